// ===== hw/rtl/ets_pkg.sv =====
// Shared types, constants and fixed-point helpers of the excitable tissue stencil step.
`timescale 1ns / 1ps

package ets_pkg;

   // Default number of fraction bits of the Q format
   localparam int FRAC_BITS_DEFAULT = 24;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_TIME_STEP      = 3'd0,
      REG_DIFF_GAIN_X    = 3'd1,
      REG_DIFF_GAIN_Y    = 3'd2,
      REG_CUBIC_GAIN     = 3'd3,
      REG_THRESHOLD      = 3'd4,
      REG_BASE_RATE      = 3'd5,
      REG_RATE_NUM_GAIN  = 3'd6,
      REG_RATE_OFFSET    = 3'd7
   } reg_index_type;

   localparam int REG_COUNT = 8;
   localparam int REG_WIDTH = 31;

   localparam logic [REG_WIDTH-1:0] REG_RESET [REG_COUNT] = '{
      31'd6503, 31'd26012, 31'd26012, 31'd134217728,
      31'd2516582, 31'd33554, 31'd3355443, 31'd5033165
   };

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // Saturated 32-bit value with its overflow mark
   typedef struct packed {
      logic              ovf;
      logic signed [31:0] val;
   } q_type;

   // Per-item data that travels beside the divider
   typedef struct packed {
      logic signed [31:0] vc;     // v of the cell
      logic signed [31:0] kw;     // k*u times (u - a - 1)
      logic               neg;    // quotient is negative
      logic               dzero;  // denominator is zero
      logic               nneg;   // numerator is not negative
      logic               ovf;    // saturation of the kw product on the v path
   } side_type;

   function automatic logic signed [65:0] sx66(input logic [31:0] x);
      return {{34{x[31]}}, x};
   endfunction

   function automatic logic signed [65:0] ux66(input logic [REG_WIDTH-1:0] x);
      return {35'd0, x};
   endfunction

   function automatic logic signed [32:0] sx33(input logic [31:0] x);
      return {x[31], x};
   endfunction

   function automatic logic signed [32:0] ux33(input logic [REG_WIDTH-1:0] x);
      return {2'b00, x};
   endfunction

   // Clamp a wide exact value to 32 bits
   function automatic q_type sat_q(input logic signed [65:0] x);
      q_type r;
      if (x > sx66(Q_MAX)) begin
         r.ovf = 1'b1;
         r.val = Q_MAX;
      end else if (x < sx66(Q_MIN)) begin
         r.ovf = 1'b1;
         r.val = Q_MIN;
      end else begin
         r.ovf = 1'b0;
         r.val = x[31:0];
      end
      return r;
   endfunction

   // Fixed-point multiply: round half up, then saturate
   function automatic q_type mulq(input logic signed [32:0] a, input logic signed [32:0] b,
                                  input int frac);
      logic signed [65:0] p;
      logic signed [65:0] rnd;
      rnd = '0;
      rnd[frac-1] = 1'b1;
      p = a * b;
      p = p + rnd;
      p = p >>> frac;
      return sat_q(p);
   endfunction

endpackage

// ===== hw/rtl/ets_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data carried along.
`timescale 1ns / 1ps

module ets_div
   import ets_pkg::*;
#(
   parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [31:0]                   in_num_mag,
   input  logic [31:0]                   in_den_mag,
   input  side_type                      in_side,
   output logic                          out_valid,
   output logic [32+FRACTION_BITS-1:0]   out_quo,
   output side_type                      out_side
);

   localparam int NW = 32 + FRACTION_BITS;

   logic          vld_ff  [NW];
   logic [32:0]   rem_ff  [NW];
   logic [NW-1:0] dvd_ff  [NW];
   logic [NW-1:0] quo_ff  [NW];
   logic [31:0]   den_ff  [NW];
   side_type      side_ff [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic          prev_vld;
      logic [32:0]   prev_rem;
      logic [NW-1:0] prev_dvd;
      logic [NW-1:0] prev_quo;
      logic [31:0]   prev_den;
      side_type      prev_side;
      logic [32:0]   trial;
      logic          ge;
      logic [32:0]   rem_in;

      if (k == 0) begin : g_first
         assign prev_vld  = in_valid;
         assign prev_rem  = '0;
         assign prev_dvd  = {in_num_mag, {FRACTION_BITS{1'b0}}};
         assign prev_quo  = '0;
         assign prev_den  = in_den_mag;
         assign prev_side = in_side;
      end else begin : g_next
         assign prev_vld  = vld_ff[k-1];
         assign prev_rem  = rem_ff[k-1];
         assign prev_dvd  = dvd_ff[k-1];
         assign prev_quo  = quo_ff[k-1];
         assign prev_den  = den_ff[k-1];
         assign prev_side = side_ff[k-1];
      end

      // Shift in the next dividend bit, subtract when it fits
      always_comb begin
         trial  = {prev_rem[31:0], prev_dvd[NW-1]};
         ge     = (trial >= {1'b0, prev_den});
         rem_in = ge ? (trial - {1'b0, prev_den}) : trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         dvd_ff[k]  <= {prev_dvd[NW-2:0], 1'b0};
         quo_ff[k]  <= {prev_quo[NW-2:0], ge};
         den_ff[k]  <= prev_den;
         side_ff[k] <= prev_side;
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_quo   = quo_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

// ===== hw/rtl/excitable_tissue_stencil_step.sv =====
// Top level: pipelined forward-Euler update of one excitable-medium grid cell.
//
//   channel  ports                                   handshake
//   request  req_u_center .. req_u_below (s32 x 6)   start, busy (taken when start & !busy)
//   result   rsp_u_next, rsp_v_next, rsp_overflow    rsp_valid strobe, one cycle
//   config   csr_index (3), csr_wdata (31)           csr_we, written at the clock edge
//
// One item is taken every cycle while busy is low; each result passes stages 0 to 2, then
// the divider, which resolves one quotient bit per stage, then the tail stages before
// rsp_valid.
// busy is high only while reset is high; reset clears the valid bits and reloads the
// registers. Results are never held back: the pipeline moves on every cycle.
`timescale 1ns / 1ps

module excitable_tissue_stencil_step
   import ets_pkg::*;
#(
   parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic signed [31:0]    req_u_center,
   input  logic signed [31:0]    req_v_center,
   input  logic signed [31:0]    req_u_left,
   input  logic signed [31:0]    req_u_right,
   input  logic signed [31:0]    req_u_above,
   input  logic signed [31:0]    req_u_below,
   output logic                  rsp_valid,
   output logic signed [31:0]    rsp_u_next,
   output logic signed [31:0]    rsp_v_next,
   output logic                  rsp_overflow,
   input  logic                  csr_we,
   input  reg_index_type         csr_index,
   input  logic [REG_WIDTH-1:0]  csr_wdata
);

   localparam int NW = 32 + FRACTION_BITS;
   localparam logic signed [65:0] ONE = 66'sd1 <<< FRACTION_BITS;

   // Configuration registers
   logic [REG_WIDTH-1:0] cfg_ff [REG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            cfg_ff[i] <= REG_RESET[i];
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   logic [REG_WIDTH-1:0] dt, gx, gy, kk, th, e0, m1, m2;
   assign dt = cfg_ff[REG_TIME_STEP];
   assign gx = cfg_ff[REG_DIFF_GAIN_X];
   assign gy = cfg_ff[REG_DIFF_GAIN_Y];
   assign kk = cfg_ff[REG_CUBIC_GAIN];
   assign th = cfg_ff[REG_THRESHOLD];
   assign e0 = cfg_ff[REG_BASE_RATE];
   assign m1 = cfg_ff[REG_RATE_NUM_GAIN];
   assign m2 = cfg_ff[REG_RATE_OFFSET];

   assign busy = reset;

   // Stage 0: capture the item
   logic        s0_valid_ff;
   logic [31:0] s0_uc_ff, s0_vc_ff, s0_ul_ff, s0_ur_ff, s0_ua_ff, s0_ub_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s0_uc_ff <= req_u_center;
      s0_vc_ff <= req_v_center;
      s0_ul_ff <= req_u_left;
      s0_ur_ff <= req_u_right;
      s0_ua_ff <= req_u_above;
      s0_ub_ff <= req_u_below;
   end

   // Stage 1: Laplacians, differences, first products
   q_type lx_q, ly_q, t1_q, t2_q, w_q, den_q, ku_q, num_q, puv_q;

   always_comb begin
      lx_q  = sat_q(sx66(s0_ur_ff) + sx66(s0_ul_ff) - (sx66(s0_uc_ff) <<< 1));
      ly_q  = sat_q(sx66(s0_ua_ff) + sx66(s0_ub_ff) - (sx66(s0_uc_ff) <<< 1));
      t1_q  = sat_q(sx66(s0_uc_ff) - ux66(th));
      t2_q  = sat_q(sx66(s0_uc_ff) - ONE);
      w_q   = sat_q(sx66(s0_uc_ff) - ux66(th) - ONE);
      den_q = sat_q(sx66(s0_uc_ff) + ux66(m2));
      ku_q  = mulq(ux33(kk), sx33(s0_uc_ff), FRACTION_BITS);
      num_q = mulq(ux33(m1), sx33(s0_vc_ff), FRACTION_BITS);
      puv_q = mulq(sx33(s0_uc_ff), sx33(s0_vc_ff), FRACTION_BITS);
   end

   logic        s1_valid_ff, s1_ovf_ff;
   logic [31:0] s1_lx_ff, s1_ly_ff, s1_t1_ff, s1_t2_ff, s1_w_ff, s1_den_ff;
   logic [31:0] s1_ku_ff, s1_num_ff, s1_puv_ff, s1_uc_ff, s1_vc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_lx_ff  <= lx_q.val;
      s1_ly_ff  <= ly_q.val;
      s1_t1_ff  <= t1_q.val;
      s1_t2_ff  <= t2_q.val;
      s1_w_ff   <= w_q.val;
      s1_den_ff <= den_q.val;
      s1_ku_ff  <= ku_q.val;
      s1_num_ff <= num_q.val;
      s1_puv_ff <= puv_q.val;
      s1_uc_ff  <= s0_uc_ff;
      s1_vc_ff  <= s0_vc_ff;
      s1_ovf_ff <= lx_q.ovf | ly_q.ovf | t1_q.ovf | t2_q.ovf | w_q.ovf | den_q.ovf
                   | ku_q.ovf | num_q.ovf | puv_q.ovf;
   end

   // Stage 2: gain products, divider operand magnitudes
   q_type       dx_q, dy_q, c1_q, kw_q;
   logic [31:0] num_mag, den_mag;

   always_comb begin
      dx_q    = mulq(ux33(gx), sx33(s1_lx_ff), FRACTION_BITS);
      dy_q    = mulq(ux33(gy), sx33(s1_ly_ff), FRACTION_BITS);
      c1_q    = mulq(sx33(s1_ku_ff), sx33(s1_t1_ff), FRACTION_BITS);
      kw_q    = mulq(sx33(s1_ku_ff), sx33(s1_w_ff), FRACTION_BITS);
      num_mag = s1_num_ff[31] ? (~s1_num_ff + 32'd1) : s1_num_ff;
      den_mag = s1_den_ff[31] ? (~s1_den_ff + 32'd1) : s1_den_ff;
   end

   logic        s2_valid_ff, s2_ovf_ff;
   logic [31:0] s2_dx_ff, s2_dy_ff, s2_c1_ff, s2_t2_ff, s2_puv_ff, s2_uc_ff;
   logic [31:0] s2_num_mag_ff, s2_den_mag_ff;
   side_type    s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_dx_ff         <= dx_q.val;
      s2_dy_ff         <= dy_q.val;
      s2_c1_ff         <= c1_q.val;
      s2_t2_ff         <= s1_t2_ff;
      s2_puv_ff        <= s1_puv_ff;
      s2_uc_ff         <= s1_uc_ff;
      s2_ovf_ff        <= s1_ovf_ff | dx_q.ovf | dy_q.ovf | c1_q.ovf;
      s2_num_mag_ff    <= num_mag;
      s2_den_mag_ff    <= den_mag;
      s2_side_ff.vc    <= s1_vc_ff;
      s2_side_ff.kw    <= kw_q.val;
      s2_side_ff.neg   <= s1_num_ff[31] ^ s1_den_ff[31];
      s2_side_ff.dzero <= (s1_den_ff == 32'd0);
      s2_side_ff.nneg  <= ~s1_num_ff[31];
      s2_side_ff.ovf   <= kw_q.ovf;
   end

   // Potential path, stages 3 to 6
   q_type       diff_q, c2_q, rhsu_q, dr_q, un_q;
   logic [31:0] s3_diff_ff, s3_c2_ff, s3_puv_ff, s3_uc_ff;
   logic [31:0] s4_rhsu_ff, s4_diff_ff, s4_uc_ff;
   logic [31:0] s5_dr_ff, s5_diff_ff, s5_uc_ff;
   logic        s3_ovf_ff, s4_ovf_ff, s5_ovf_ff;
   q_type       s6_un_ff;

   always_comb begin
      diff_q = sat_q(sx66(s2_dx_ff) + sx66(s2_dy_ff));
      c2_q   = mulq(sx33(s2_c1_ff), sx33(s2_t2_ff), FRACTION_BITS);
      rhsu_q = sat_q(-sx66(s3_c2_ff) - sx66(s3_puv_ff));
      dr_q   = mulq(ux33(dt), sx33(s4_rhsu_ff), FRACTION_BITS);
      un_q   = sat_q(sx66(s5_uc_ff) + sx66(s5_diff_ff) + sx66(s5_dr_ff));
   end

   always_ff @(posedge clock) begin
      s3_diff_ff   <= diff_q.val;
      s3_c2_ff     <= c2_q.val;
      s3_puv_ff    <= s2_puv_ff;
      s3_uc_ff     <= s2_uc_ff;
      s3_ovf_ff    <= s2_ovf_ff | diff_q.ovf | c2_q.ovf;
      s4_rhsu_ff   <= rhsu_q.val;
      s4_diff_ff   <= s3_diff_ff;
      s4_uc_ff     <= s3_uc_ff;
      s4_ovf_ff    <= s3_ovf_ff | rhsu_q.ovf;
      s5_dr_ff     <= dr_q.val;
      s5_diff_ff   <= s4_diff_ff;
      s5_uc_ff     <= s4_uc_ff;
      s5_ovf_ff    <= s4_ovf_ff | dr_q.ovf;
      s6_un_ff.val <= un_q.val;
      s6_un_ff.ovf <= s5_ovf_ff | un_q.ovf;
   end

   // Hold the new potential until the recovery path catches up
   q_type un_dly_ff [NW];

   always_ff @(posedge clock) begin
      un_dly_ff[0] <= s6_un_ff;
      for (int j = 1; j < NW; j++) begin
         un_dly_ff[j] <= un_dly_ff[j-1];
      end
   end

   // Divider for the rate quotient
   logic          div_valid;
   logic [NW-1:0] div_quo;
   side_type      div_side;

   ets_div #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid_ff),
      .in_num_mag (s2_num_mag_ff),
      .in_den_mag (s2_den_mag_ff),
      .in_side    (s2_side_ff),
      .out_valid  (div_valid),
      .out_quo    (div_quo),
      .out_side   (div_side)
   );

   // Tail stage 1: signed, saturated quotient and recovery drive
   q_type quot_q, rv_q;

   always_comb begin
      rv_q = sat_q(-sx66(div_side.vc) - sx66(div_side.kw));
      if (div_side.dzero) begin
         quot_q.ovf = 1'b1;
         quot_q.val = div_side.nneg ? Q_MAX : Q_MIN;
      end else if (div_side.neg) begin
         quot_q.ovf = (|div_quo[NW-1:32]) | (div_quo[31] & (|div_quo[30:0]));
         quot_q.val = quot_q.ovf ? Q_MIN : (~div_quo[31:0] + 32'd1);
      end else begin
         quot_q.ovf = |div_quo[NW-1:31];
         quot_q.val = quot_q.ovf ? Q_MAX : div_quo[31:0];
      end
   end

   logic        t1_valid_ff, t2_valid_ff, t3_valid_ff, t4_valid_ff;
   logic [31:0] t1_quot_ff, t1_rv_ff, t1_vc_ff;
   logic        t1_ovf_ff, t2_ovf_ff, t3_ovf_ff, t4_ovf_ff;
   logic [31:0] t2_eps_ff, t2_rv_ff, t2_vc_ff;
   logic [31:0] t3_rhsv_ff, t3_vc_ff;
   logic [31:0] t4_dvr_ff, t4_vc_ff;
   q_type       eps_q, rhsv_q, dvr_q, vn_q;
   q_type       un_out;

   always_comb begin
      eps_q  = sat_q(ux66(e0) + sx66(t1_quot_ff));
      rhsv_q = mulq(sx33(t2_eps_ff), sx33(t2_rv_ff), FRACTION_BITS);
      dvr_q  = mulq(ux33(dt), sx33(t3_rhsv_ff), FRACTION_BITS);
      vn_q   = sat_q(sx66(t4_vc_ff) + sx66(t4_dvr_ff));
      un_out = un_dly_ff[NW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff  <= 1'b0;
         t2_valid_ff  <= 1'b0;
         t3_valid_ff  <= 1'b0;
         t4_valid_ff  <= 1'b0;
         rsp_valid    <= 1'b0;
      end else begin
         t1_valid_ff  <= div_valid;
         t2_valid_ff  <= t1_valid_ff;
         t3_valid_ff  <= t2_valid_ff;
         t4_valid_ff  <= t3_valid_ff;
         rsp_valid    <= t4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      t1_quot_ff   <= quot_q.val;
      t1_rv_ff     <= rv_q.val;
      t1_vc_ff     <= div_side.vc;
      t1_ovf_ff    <= div_side.ovf | quot_q.ovf | rv_q.ovf;
      t2_eps_ff    <= eps_q.val;
      t2_rv_ff     <= t1_rv_ff;
      t2_vc_ff     <= t1_vc_ff;
      t2_ovf_ff    <= t1_ovf_ff | eps_q.ovf;
      t3_rhsv_ff   <= rhsv_q.val;
      t3_vc_ff     <= t2_vc_ff;
      t3_ovf_ff    <= t2_ovf_ff | rhsv_q.ovf;
      t4_dvr_ff    <= dvr_q.val;
      t4_vc_ff     <= t3_vc_ff;
      t4_ovf_ff    <= t3_ovf_ff | dvr_q.ovf;
      rsp_u_next   <= un_out.val;
      rsp_v_next   <= vn_q.val;
      rsp_overflow <= t4_ovf_ff | vn_q.ovf | un_out.ovf;
   end

endmodule

// ===== hw/rtl/ets_checker.sv =====
// Port-level checks of the stencil step: fixed latency and reset behavior.
`timescale 1ns / 1ps

module ets_checker
   import ets_pkg::*;
#(
   parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // Edges from the edge that takes an item to the edge that takes its result
   localparam int LATENCY = 40 + FRACTION_BITS;

   // Every accepted item yields its result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("item accepted without result at the expected cycle");

   // No result without an item accepted the fixed latency earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching item");

   // Reset empties the pipeline
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind excitable_tissue_stencil_step ets_checker #(
   .FRACTION_BITS (FRACTION_BITS)
) u_ets_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
